>>> hw/rtl/cst_pkg.sv
package cst_pkg;

   localparam logic [2:0] KEYWORD_LEN = 3'd6;

   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_UNKNOWN = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_NUMBER  = 4'd3,
      KIND_RETURN  = 4'd4,
      KIND_SEMI    = 4'd5,
      KIND_ASSIGN  = 4'd6,
      KIND_PLUS    = 4'd7,
      KIND_MINUS   = 4'd8,
      KIND_STAR    = 4'd9,
      KIND_SLASH   = 4'd10,
      KIND_LPAREN  = 4'd11,
      KIND_RPAREN  = 4'd12
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   // up to two tokens per request: a finished run, then the byte's own token
   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      token_type first;
      token_type second;
   } emit_type;

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0C ||
             c == 8'h0B || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         8'h3B:   k = KIND_SEMI;
         8'h3D:   k = KIND_ASSIGN;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h72;
         3'd1:    ch = 8'h65;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h75;
         3'd4:    ch = 8'h72;
         3'd5:    ch = 8'h6E;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/cst_if.sv
interface cst_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface cst_token_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] token_start;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input last_of_run, output ready);
endinterface

>>> hw/rtl/cst_scanner.sv
module cst_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        char_code,
   output cst_pkg::emit_type emit
);

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_LETTERS = 2'd1,
      MODE_DIGITS  = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [2:0]  prog_ff, prog_in;
   logic        miss_ff, miss_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] pos_ff, pos_in;
   logic        ended_ff, ended_in;

   logic                 run_v;
   logic                 byte_v;
   cst_pkg::token_type   run_tok;
   cst_pkg::token_type   byte_tok;

   always_comb begin
      mode_in  = mode_ff;
      prog_in  = prog_ff;
      miss_in  = miss_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      ended_in = ended_ff;
      run_v    = 1'b0;
      byte_v   = 1'b0;
      run_tok  = '0;
      byte_tok = '0;

      if (ended_ff) begin
         byte_v         = 1'b1;
         byte_tok.kind  = cst_pkg::KIND_END;
         byte_tok.start = pos_ff;
      end else if ((mode_ff == MODE_LETTERS && cst_pkg::is_letter(char_code)) ||
                   (mode_ff == MODE_DIGITS && cst_pkg::is_digit(char_code))) begin
         if (len_ff != 16'hFFFF) begin
            len_in = len_ff + 16'd1;
         end
         if (mode_ff == MODE_LETTERS && !miss_ff) begin
            if (prog_ff < cst_pkg::KEYWORD_LEN &&
                char_code == cst_pkg::keyword_char(prog_ff)) begin
               prog_in = prog_ff + 3'd1;
            end else begin
               miss_in = 1'b1;
            end
         end
         pos_in = pos_ff + 32'd1;
      end else begin
         if (mode_ff == MODE_LETTERS) begin
            run_v         = 1'b1;
            run_tok.kind  = (!miss_ff && prog_ff == cst_pkg::KEYWORD_LEN) ?
                            cst_pkg::KIND_RETURN : cst_pkg::KIND_IDENT;
            run_tok.start = start_ff;
            run_tok.length = len_ff;
         end else if (mode_ff == MODE_DIGITS) begin
            run_v          = 1'b1;
            run_tok.kind   = cst_pkg::KIND_NUMBER;
            run_tok.start  = start_ff;
            run_tok.length = len_ff;
         end
         mode_in = MODE_IDLE;

         if (char_code == 8'h00) begin
            byte_v         = 1'b1;
            byte_tok.kind  = cst_pkg::KIND_END;
            byte_tok.start = pos_ff;
            ended_in       = 1'b1;
         end else if (cst_pkg::is_space(char_code)) begin
            mode_in = MODE_IDLE;
         end else if (cst_pkg::is_letter(char_code)) begin
            mode_in  = MODE_LETTERS;
            start_in = pos_ff;
            len_in   = 16'd1;
            if (char_code == cst_pkg::keyword_char(3'd0)) begin
               prog_in = 3'd1;
               miss_in = 1'b0;
            end else begin
               prog_in = 3'd0;
               miss_in = 1'b1;
            end
         end else if (cst_pkg::is_digit(char_code)) begin
            mode_in  = MODE_DIGITS;
            start_in = pos_ff;
            len_in   = 16'd1;
            prog_in  = 3'd0;
            miss_in  = 1'b0;
         end else begin
            byte_v          = 1'b1;
            byte_tok.kind   = cst_pkg::punct_kind(char_code);
            byte_tok.start  = pos_ff;
            byte_tok.length = 16'd1;
         end

         if (char_code != 8'h00) begin
            pos_in = pos_ff + 32'd1;
         end
      end
   end

   always_comb begin
      emit              = '0;
      emit.first_valid  = run_v || byte_v;
      emit.second_valid = run_v && byte_v;
      emit.first        = run_v ? run_tok : byte_tok;
      emit.first.last   = !(run_v && byte_v);
      emit.second       = byte_tok;
      emit.second.last  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         prog_ff  <= '0;
         miss_ff  <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         ended_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         prog_ff  <= prog_in;
         miss_ff  <= miss_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         ended_ff <= ended_in;
      end
   end

`ifndef SYNTH
   a_prog_range: assert property (@(posedge clock) disable iff (reset)
      prog_ff <= cst_pkg::KEYWORD_LEN)
      else $error("keyword progress out of range");
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      ended_ff && step |=> ended_ff && $stable(pos_ff))
      else $error("end of input did not hold");
   a_end_alone: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> emit.first_valid && !emit.second_valid &&
                   emit.first.kind == cst_pkg::KIND_END)
      else $error("bad token after end of input");
`endif

endmodule

>>> hw/rtl/cst_token_fifo.sv
module cst_token_fifo #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cst_pkg::emit_type  emit,
   input  logic               push,
   output logic               room,
   output logic               out_valid,
   input  logic               pop,
   output cst_pkg::token_type out_token
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

   cst_pkg::token_type mem [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] wr_next;
   logic            do_pop;
   logic            wr0, wr1;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == LastIdx) ? '0 : p + PtrW'(1);
   endfunction

   assign room      = count_ff <= RoomMax;
   assign out_valid = count_ff != '0;
   assign out_token = mem[rd_ptr_ff];
   assign do_pop    = pop && out_valid;
   assign wr0       = push && emit.first_valid;
   assign wr1       = push && emit.second_valid;
   assign wr_next   = bump(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (wr1) begin
         wr_ptr_in = bump(wr_next);
      end else if (wr0) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(wr0) + CntW'(wr1) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr0) begin
         mem[wr_ptr_ff] <= emit.first;
      end
      if (wr1) begin
         mem[wr_next] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("write without room");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count overflow");
   a_pair_count: assert property (@(posedge clock) disable iff (reset)
      wr1 && !do_pop |=> count_ff == $past(count_ff) + CntW'(2))
      else $error("two-token write lost an entry");
`endif

endmodule

>>> hw/rtl/char_stream_tokenizer.sv
// Byte-serial tokenizer. One source byte is taken per request on req_bus and
// zero, one or two tokens come out on rsp_bus in source order; last_of_run
// marks the final token caused by a byte. A byte is accepted in the cycle it
// is offered whenever the token queue (FifoDepth entries, at least 3) has two
// free slots, so the input sustains one byte per clock while rsp_bus keeps up;
// bytes that close a run and emit two tokens drain at one token per clock.
// Tokens are written into the queue when their byte is accepted, and rsp_bus
// shows the queue head. Byte zero ends the input; every later byte yields
// another end token at the same offset until reset.
module char_stream_tokenizer #(
   parameter int FifoDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   cst_char_if.sink    req_bus,
   cst_token_if.source rsp_bus
);

   cst_pkg::emit_type  emit;
   cst_pkg::token_type head;
   logic               room;
   logic               step;
   logic               out_valid;

   assign req_bus.ready = room;
   assign step          = req_bus.valid && room;

   cst_scanner u_scanner (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (req_bus.char_code),
      .emit      (emit)
   );

   cst_token_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .push      (step),
      .room      (room),
      .out_valid (out_valid),
      .pop       (rsp_bus.ready),
      .out_token (head)
   );

   assign rsp_bus.valid        = out_valid;
   assign rsp_bus.token_kind   = head.kind;
   assign rsp_bus.token_start  = head.start;
   assign rsp_bus.token_length = head.length;
   assign rsp_bus.last_of_run  = head.last;

`ifndef SYNTH
   a_end_length: assert property (@(posedge clock) disable iff (reset)
      out_valid && head.kind == cst_pkg::KIND_END |-> head.length == 16'd0 && head.last)
      else $error("end token malformed");
   a_punct_length: assert property (@(posedge clock) disable iff (reset)
      out_valid && head.kind != cst_pkg::KIND_END && head.kind != cst_pkg::KIND_IDENT &&
      head.kind != cst_pkg::KIND_NUMBER && head.kind != cst_pkg::KIND_RETURN
      |-> head.length == 16'd1 && head.last)
      else $error("single-byte token malformed");
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      out_valid && (head.kind == cst_pkg::KIND_IDENT || head.kind == cst_pkg::KIND_NUMBER ||
      head.kind == cst_pkg::KIND_RETURN) |-> head.length != 16'd0)
      else $error("empty run token");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

class token_scoreboard;
   typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_state_type;

   scan_state_type       scan;
   logic [2:0]           kw_matched;
   logic                 kw_broken;
   logic [31:0]          run_begin;
   logic [15:0]          run_len;
   logic [31:0]          next_offset;
   logic                 stream_done;
   string                kw_text;
   cst_pkg::token_type   expected_tokens[$];
   int                   failures;

   function new();
      scan        = SCAN_IDLE;
      kw_matched  = '0;
      kw_broken   = 1'b0;
      run_begin   = '0;
      run_len     = '0;
      next_offset = '0;
      stream_done = 1'b0;
      kw_text     = "return";
      failures    = 0;
   endfunction

   function int pending();
      return expected_tokens.size();
   endfunction

   function logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A ||
             c == 8'h0B || c == 8'h0C || c == 8'h0D;
   endfunction

   function logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function cst_pkg::kind_type symbol_kind(input logic [7:0] c);
      case (c)
         ";":     return cst_pkg::KIND_SEMI;
         "=":     return cst_pkg::KIND_ASSIGN;
         "+":     return cst_pkg::KIND_PLUS;
         "-":     return cst_pkg::KIND_MINUS;
         "*":     return cst_pkg::KIND_STAR;
         "/":     return cst_pkg::KIND_SLASH;
         "(":     return cst_pkg::KIND_LPAREN;
         ")":     return cst_pkg::KIND_RPAREN;
         default: return cst_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   function cst_pkg::token_type make_token(input cst_pkg::kind_type k,
                                           input logic [31:0] s,
                                           input logic [15:0] n);
      cst_pkg::token_type t;
      t.kind   = k;
      t.start  = s;
      t.length = n;
      t.last   = 1'b0;
      return t;
   endfunction

   function void track_keyword(input logic [7:0] c);
      if (!kw_broken) begin
         if (kw_matched < cst_pkg::KEYWORD_LEN && c == kw_text[kw_matched])
            kw_matched = kw_matched + 3'd1;
         else
            kw_broken = 1'b1;
      end
   endfunction

   function void grow_run();
      if (run_len != 16'hFFFF)
         run_len = run_len + 16'd1;
   endfunction

   // predicts the tokens caused by one accepted request
   function void note_byte(input logic [7:0] c);
      cst_pkg::token_type found[$];
      logic [31:0]        here;
      here = next_offset;
      if (stream_done) begin
         found.push_back(make_token(cst_pkg::KIND_END, here, 16'd0));
      end else if (scan == SCAN_WORD && is_alpha(c)) begin
         grow_run();
         track_keyword(c);
         next_offset = here + 32'd1;
      end else if (scan == SCAN_NUMBER && is_numeral(c)) begin
         grow_run();
         next_offset = here + 32'd1;
      end else begin
         if (scan == SCAN_WORD)
            found.push_back(make_token(
               (!kw_broken && kw_matched == cst_pkg::KEYWORD_LEN) ?
               cst_pkg::KIND_RETURN : cst_pkg::KIND_IDENT, run_begin, run_len));
         else if (scan == SCAN_NUMBER)
            found.push_back(make_token(cst_pkg::KIND_NUMBER, run_begin, run_len));
         scan = SCAN_IDLE;
         if (c == 8'h00) begin
            found.push_back(make_token(cst_pkg::KIND_END, here, 16'd0));
            stream_done = 1'b1;
         end else if (is_blank(c)) begin
         end else if (is_alpha(c)) begin
            scan       = SCAN_WORD;
            run_begin  = here;
            run_len    = 16'd1;
            kw_matched = '0;
            kw_broken  = 1'b0;
            track_keyword(c);
         end else if (is_numeral(c)) begin
            scan       = SCAN_NUMBER;
            run_begin  = here;
            run_len    = 16'd1;
            kw_matched = '0;
            kw_broken  = 1'b0;
         end else begin
            found.push_back(make_token(symbol_kind(c), here, 16'd1));
         end
         if (c != 8'h00)
            next_offset = here + 32'd1;
      end
      if (found.size() > 0)
         found[found.size() - 1].last = 1'b1;
      foreach (found[i])
         expected_tokens.push_back(found[i]);
   endfunction

   function void check_token(input logic [3:0] kind, input logic [31:0] start,
                             input logic [15:0] len, input logic last);
      cst_pkg::token_type want;
      if (expected_tokens.size() == 0) begin
         $error("token with no request pending: kind %0d start %0d", kind, start);
         failures++;
         return;
      end
      want = expected_tokens.pop_front();
      if (want.kind != kind) begin
         $error("token_kind expected %0d actual %0d", want.kind, kind);
         failures++;
      end
      if (want.start != start) begin
         $error("token_start expected %0d actual %0d", want.start, start);
         failures++;
      end
      if (want.length != len) begin
         $error("token_length expected %0d actual %0d", want.length, len);
         failures++;
      end
      if (want.last != last) begin
         $error("last_of_run expected %0d actual %0d", want.last, last);
         failures++;
      end
   endfunction
endclass

module tb_top;
   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_cycles;
   int   chars_sent;

   token_scoreboard sb = new();

   cst_char_if  req_if();
   cst_token_if rsp_if();

   char_stream_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_byte(req_if.char_code);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_token(rsp_if.token_kind, rsp_if.token_start,
                           rsp_if.token_length, rsp_if.last_of_run);
      end
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_if.valid     = 1'b1;
      req_if.char_code = c;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   task automatic drain_tokens();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
   endfunction

   // mostly well-formed lexemes back to back, with some raw noise bytes
   task automatic send_random_text(input int goal);
      string      near_words[6] = '{"retur", "returns", "Return", "RETURN",
                                    "xreturn", "returnreturn"};
      string      symbols = ";=+-*/()";
      logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0C, 8'h0B, 8'h0D, 8'h0A};
      int         pick;
      int         n;
      while (chars_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_text("return");
         end else if (pick < 25) begin
            send_text(near_words[$urandom_range(5)]);
         end else if (pick < 45) begin
            n = $urandom_range(8, 1);
            repeat (n) send_char(random_letter());
         end else if (pick < 60) begin
            n = $urandom_range(6, 1);
            repeat (n) send_char(8'h30 + 8'($urandom_range(9)));
         end else if (pick < 75) begin
            send_char(symbols[$urandom_range(7)]);
         end else if (pick < 88) begin
            n = $urandom_range(3, 1);
            repeat (n) send_char(blanks[$urandom_range(5)]);
         end else begin
            send_char(8'($urandom_range(255, 1)));
         end
      end
   endtask

   initial begin
      logic [7:0] edge_bytes[11];
      edge_bytes       = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h09, 8'h0B,
                           8'h0C, 8'h0D, 8'h0A, 8'hFF, 8'h80};
      req_if.valid     = 1'b0;
      req_if.char_code = 8'h00;
      reset            = 1'b1;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_cycles      = 0;
      chars_sent       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text("return;x=(9+Az)-0*b/");
      foreach (edge_bytes[i])
         send_char(edge_bytes[i]);
      drain_tokens();

      // receiver holds off, queue fills and input stalls
      hold_cycles = 300;
      send_random_text(chars_sent + 40);
      drain_tokens();

      send_random_text(chars_sent + 165);
      drain_tokens();
      send_idle_pct = 59;
      send_random_text(chars_sent + 165);
      drain_tokens();
      send_idle_pct  = 0;
      recv_stall_pct = 59;
      send_random_text(chars_sent + 165);
      drain_tokens();
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      send_random_text(chars_sent + 165);

      // keyword closed by end of input, then bytes after the end
      send_text("ab1 return");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h00);
      send_char("a");
      drain_tokens();
      repeat (10) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
